// ===== design/tsa_pkg.sv =====
// ============================================================================
// tsa_pkg
// Shared types and constants of the TDMA slot allocator.
// ============================================================================
package tsa_pkg;

   // Field widths
   localparam int NODE_W      = 5;
   localparam int PER_W       = 7;
   localparam int OFF_W       = 13;
   localparam int TILE_W      = 7;
   localparam int SF_W        = 5;
   localparam int TIDX_W      = 4;
   localparam int MASK_W      = 16;
   localparam int LEN_W       = 32;
   localparam int PROD_W      = LEN_W + PER_W;
   localparam int STATUS_W    = 3;
   localparam int OP_W        = 2;
   localparam int SLOT_OFF_W  = 12;
   localparam int ENTRY_CNT_W = 9;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 56;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Shared divider
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 13;
   localparam int DIV_CNT_W = 6;

   // Limits and reset values
   localparam logic [TILE_W-1:0] TILE_CAP     = 7'd64;
   localparam logic [SF_W-1:0]   SF_CAP       = 5'd16;
   localparam logic [LEN_W-1:0]  LEN_SAT      = 32'hFFFF_FFFF;
   localparam logic [TILE_W-1:0] RST_TILE     = 7'd10;
   localparam logic [TILE_W-1:0] RST_DL_CTRL  = 7'd2;
   localparam logic [TILE_W-1:0] RST_UL_CTRL  = 7'd2;
   localparam logic [SF_W-1:0]   RST_SF       = 5'd2;
   localparam logic [MASK_W-1:0] RST_DL_MASK  = 16'd1;
   localparam logic [MASK_W-1:0] RST_UL_MASK  = 16'd2;

   typedef enum logic [OP_W-1:0] {
      OP_EDGE  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_PLACE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 3'd0,
      ST_PLACED  = 3'd1,
      ST_NO_LINK = 3'd2,
      ST_NO_SLOT = 3'd3,
      ST_SKIPPED = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_SLOTS = 3'd0,
      CSR_DL_CTRL    = 3'd1,
      CSR_UL_CTRL    = 3'd2,
      CSR_SF_TILES   = 3'd3,
      CSR_DL_MASK    = 3'd4,
      CSR_UL_MASK    = 3'd5
   } csr_idx_type;

   // One schedule table entry
   typedef struct packed {
      logic [NODE_W-1:0] tx;
      logic [NODE_W-1:0] rx;
      logic [PER_W-1:0]  per;
      logic [OFF_W-1:0]  off;
   } ent_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [PER_W-1:0] x;
      logic [PER_W-1:0] y;
   } gcd_req_type;

   typedef struct packed {
      logic             done;
      logic [PER_W-1:0] g;
   } gcd_rsp_type;

endpackage

// ===== design/tsa_ram.sv =====
// ============================================================================
// tsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module tsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tsa_div.sv =====
// ============================================================================
// tsa_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ============================================================================
module tsa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tsa_pkg::div_req_type req,
   output tsa_pkg::div_rsp_type rsp
);

   localparam int NW = tsa_pkg::DIV_NUM_W;
   localparam int DW = tsa_pkg::DIV_DEN_W;
   localparam int CW = tsa_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quot_ff, quot_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quot_ff[NW-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DW'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = trial[DW-1:0];
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== design/tsa_gcd.sv =====
// ============================================================================
// tsa_gcd
// Subtractive greatest common divisor of two period-wide values.
// ============================================================================
module tsa_gcd (
   input  logic                 clock,
   input  logic                 reset,
   input  tsa_pkg::gcd_req_type req,
   output tsa_pkg::gcd_rsp_type rsp
);

   localparam int PW = tsa_pkg::PER_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [PW-1:0] x_ff, x_in;
   logic [PW-1:0] y_ff, y_in;

   // One subtract or swap a cycle until y runs out
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      if (req.start) begin
         busy_in = 1'b1;
         x_in    = req.x;
         y_in    = req.y;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (x_ff < y_ff) begin
            x_in = y_ff;
            y_in = x_ff;
         end else begin
            x_in = x_ff - y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign rsp.done = done_ff;
   assign rsp.g    = x_ff;

endmodule

// ===== design/tdma_slot_allocator_core.sv =====
// ============================================================================
// tdma_slot_allocator_core
// Places stream hops into a periodic TDMA schedule held in on-chip RAM.
// ============================================================================
//
//  Channel | Dir | Handshake             | Payload
//  --------+-----+-----------------------+----------------------------------
//  req     | in  | req_tvalid/req_tready | op in tuser, hop/edge in tdata
//  rsp     | out | rsp_tvalid/rsp_tready | status in tuser, results in tdata
//  csr     | in  | csr_valid/csr_ready   | register index and write data
//
// One item at a time. An edge write reads the row and writes it back patched;
// a clear or a skipped hop goes straight to the result. A hop reads both
// adjacency rows and splits its start offset with the divider, then tries
// offsets in turn against each stored entry; a related entry (shared node or
// edge) costs a gcd and a divide. Placing stores the hop and updates the lcm.
// Reset is synchronous; adjacency rows read as zero until first written.
// A result waiting on rsp stalls only the final load of the next result.
// ============================================================================
module tdma_slot_allocator_core #(
   parameter int MAX_NODES   = 32,
   parameter int MAX_ENTRIES = 256,
   parameter int MAX_PERIOD  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // requests
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node_a[4:0], node_b[9:5], edge_present[10], period_tiles[17:11],
   // first_hop[18], zero fill
   input  logic [tsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[1:0]
   input  logic [tsa_pkg::OP_W-1:0]          req_tuser,
   // responses
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_offset[11:0], schedule_tiles[43:12], entry_count[52:44], zero fill
   output logic [tsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[2:0]
   output logic [tsa_pkg::STATUS_W-1:0]      rsp_tuser,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsa_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int EW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = tsa_pkg::PER_W;
   localparam int OW = tsa_pkg::OFF_W;
   localparam int TW = tsa_pkg::TILE_W;
   localparam int LW = tsa_pkg::LEN_W;
   localparam int NDW = tsa_pkg::NODE_W;
   localparam logic [PW-1:0] PER_CAP = (MAX_PERIOD > 127) ? 7'd127 : PW'(MAX_PERIOD);

   typedef enum logic [4:0] {
      S_IDLE,
      S_EDGE_RD,
      S_EDGE_WR,
      S_HOP_RDA,
      S_HOP_RDB,
      S_HOP_CHK,
      S_DIV_OFF,
      S_DIV_TILE,
      S_SCAN,
      S_ENT_RD,
      S_ENT_CHK,
      S_GCD_M,
      S_DIV_M,
      S_PLACE,
      S_LCM_DIV1,
      S_LCM_GCD,
      S_LCM_DIV2,
      S_LCM_MUL,
      S_FINISH
   } state_type;

   // Configuration registers
   logic [TW-1:0]                  tile_slots_ff;
   logic [TW-1:0]                  dl_ctrl_ff;
   logic [TW-1:0]                  ul_ctrl_ff;
   logic [tsa_pkg::SF_W-1:0]       sf_ff;
   logic [tsa_pkg::MASK_W-1:0]     dl_mask_ff;
   logic [tsa_pkg::MASK_W-1:0]     ul_mask_ff;

   // Control state
   state_type                      state_ff, state_in;
   logic                           go_ff, go_in;
   logic [EW-1:0]                  entries_ff, entries_in;
   logic [LW-1:0]                  sched_len_ff, sched_len_in;
   logic [EW-1:0]                  start_cnt_ff, start_cnt_in;
   logic [LW-1:0]                  len_before_ff, len_before_in;
   logic                           failed_ff, failed_in;
   logic [OW-1:0]                  next_off_ff, next_off_in;
   logic [MAX_NODES-1:0]           adj_valid_ff, adj_valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Per-item working registers
   logic [NDW-1:0]                 a_ff, a_in;
   logic [NDW-1:0]                 b_ff, b_in;
   logic                           present_ff, present_in;
   logic [PW-1:0]                  per_ff, per_in;
   tsa_pkg::status_type            status_ff, status_in;
   logic [OW-1:0]                  off_ff, off_in;
   logic [TW-1:0]                  sl_ff, sl_in;
   logic [tsa_pkg::TIDX_W-1:0]     ti_ff, ti_in;
   logic [OW-1:0]                  limit_ff, limit_in;
   logic [EW-1:0]                  i_ff, i_in;
   tsa_pkg::ent_type               ent_ff, ent_in;
   logic [OW-1:0]                  m_ff, m_in;
   logic [tsa_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [MAX_NODES-1:0]           row_a_ff, row_a_in;
   logic [MAX_NODES-1:0]           row_b_ff, row_b_in;

   // Output register
   tsa_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [tsa_pkg::SLOT_OFF_W-1:0] rsp_off_ff, rsp_off_in;
   logic [LW-1:0]                  rsp_len_ff, rsp_len_in;
   logic [tsa_pkg::ENTRY_CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // Memories and shared units
   logic                           adj_wr_en;
   logic [NW-1:0]                  adj_rd_addr;
   logic [MAX_NODES-1:0]           adj_wr_data;
   logic [MAX_NODES-1:0]           adj_rd_data;
   logic                           tbl_wr_en;
   tsa_pkg::ent_type               tbl_wr_data;
   tsa_pkg::ent_type               tbl_rd_data;
   tsa_pkg::div_req_type           div_req;
   tsa_pkg::div_rsp_type           div_rsp;
   tsa_pkg::gcd_req_type           gcd_req;
   tsa_pkg::gcd_rsp_type           gcd_rsp;

   // Helpers
   logic [TW-1:0]                  t_eff;
   logic [tsa_pkg::SF_W-1:0]       sf_eff;
   logic [NW-1:0]                  a_idx, b_idx;
   logic                           a_ok, b_ok;
   logic [PW-1:0]                  in_per;
   logic [NDW-1:0]                 in_a;
   tsa_pkg::op_type                in_op;
   logic                           in_first;
   logic [OW-1:0]                  off_step;
   logic [TW-1:0]                  sl_step;
   logic [tsa_pkg::TIDX_W-1:0]     ti_step;
   logic                           ctrl_slot;
   logic [2*TW-1:0]                lim_prod;
   logic [2*TW-1:0]                m_prod;
   logic [OW-1:0]                  off_diff;
   logic                           share, link, related;
   logic [MAX_NODES-1:0]           edge_row;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_slots_ff <= tsa_pkg::RST_TILE;
         dl_ctrl_ff    <= tsa_pkg::RST_DL_CTRL;
         ul_ctrl_ff    <= tsa_pkg::RST_UL_CTRL;
         sf_ff         <= tsa_pkg::RST_SF;
         dl_mask_ff    <= tsa_pkg::RST_DL_MASK;
         ul_mask_ff    <= tsa_pkg::RST_UL_MASK;
      end else if (csr_valid) begin
         case (tsa_pkg::csr_idx_type'(csr_index))
            tsa_pkg::CSR_TILE_SLOTS: tile_slots_ff <= csr_data[TW-1:0];
            tsa_pkg::CSR_DL_CTRL:    dl_ctrl_ff    <= csr_data[TW-1:0];
            tsa_pkg::CSR_UL_CTRL:    ul_ctrl_ff    <= csr_data[TW-1:0];
            tsa_pkg::CSR_SF_TILES:   sf_ff         <= csr_data[tsa_pkg::SF_W-1:0];
            tsa_pkg::CSR_DL_MASK:    dl_mask_ff    <= csr_data;
            tsa_pkg::CSR_UL_MASK:    ul_mask_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped configuration
   assign t_eff  = (tile_slots_ff == '0) ? TW'(1) :
                   (tile_slots_ff > tsa_pkg::TILE_CAP) ? tsa_pkg::TILE_CAP : tile_slots_ff;
   assign sf_eff = (sf_ff == '0) ? tsa_pkg::SF_W'(1) :
                   (sf_ff > tsa_pkg::SF_CAP) ? tsa_pkg::SF_CAP : sf_ff;

   // Request fields
   assign in_op    = tsa_pkg::op_type'(req_tuser);
   assign in_a     = req_tdata[4:0];
   assign in_first = req_tdata[18];
   assign in_per   = (req_tdata[17:11] == '0) ? PW'(1) :
                     (req_tdata[17:11] > PER_CAP) ? PER_CAP : req_tdata[17:11];

   assign a_idx = NW'(a_ff);
   assign b_idx = NW'(b_ff);
   assign a_ok  = (32'(a_ff) < MAX_NODES);
   assign b_ok  = (32'(b_ff) < MAX_NODES);

   // Offset walk: slot within tile and tile index within superframe
   assign off_step = off_ff + 1'b1;
   always_comb begin
      sl_step = sl_ff + 1'b1;
      ti_step = ti_ff;
      if (sl_step == t_eff) begin
         sl_step = '0;
         if (({1'b0, ti_ff} + 1'b1) == sf_eff) begin
            ti_step = '0;
         end else begin
            ti_step = ti_ff + 1'b1;
         end
      end
   end

   assign ctrl_slot = (dl_mask_ff[ti_ff] && (sl_ff <= dl_ctrl_ff)) ||
                      (ul_mask_ff[ti_ff] && (sl_ff <= ul_ctrl_ff));

   assign lim_prod = (2*TW)'(per_ff) * (2*TW)'(t_eff);
   assign m_prod   = (2*TW)'(t_eff) * (2*TW)'(gcd_rsp.g);
   assign off_diff = (off_ff >= ent_ff.off) ? (off_ff - ent_ff.off) : (ent_ff.off - off_ff);

   // Node relation of the hop to the entry just read
   assign share = (a_ff == tbl_rd_data.tx) || (a_ff == tbl_rd_data.rx) ||
                  (b_ff == tbl_rd_data.tx) || (b_ff == tbl_rd_data.rx);
   assign link  = ((32'(tbl_rd_data.rx) < MAX_NODES) && row_a_ff[NW'(tbl_rd_data.rx)]) ||
                  ((32'(tbl_rd_data.tx) < MAX_NODES) && row_b_ff[NW'(tbl_rd_data.tx)]);
   assign related = share || link;

   // Edge write data: read row, patch one bit
   always_comb begin
      edge_row = adj_valid_ff[a_idx] ? adj_rd_data : '0;
      edge_row[b_idx] = present_ff;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      entries_in    = entries_ff;
      sched_len_in  = sched_len_ff;
      start_cnt_in  = start_cnt_ff;
      len_before_in = len_before_ff;
      failed_in     = failed_ff;
      next_off_in   = next_off_ff;
      adj_valid_in  = adj_valid_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      present_in    = present_ff;
      per_in        = per_ff;
      status_in     = status_ff;
      off_in        = off_ff;
      sl_in         = sl_ff;
      ti_in         = ti_ff;
      limit_in      = limit_ff;
      i_in          = i_ff;
      ent_in        = ent_ff;
      m_in          = m_ff;
      prod_in       = prod_ff;
      row_a_in      = row_a_ff;
      row_b_in      = row_b_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      adj_wr_en   = 1'b0;
      adj_wr_data = edge_row;
      adj_rd_addr = a_idx;
      tbl_wr_en   = 1'b0;
      tbl_wr_data = '{tx: a_ff, rx: b_ff, per: per_ff, off: off_ff};

      div_req.start = 1'b0;
      div_req.num   = tsa_pkg::DIV_NUM_W'(next_off_ff);
      div_req.den   = tsa_pkg::DIV_DEN_W'(t_eff);
      gcd_req.start = 1'b0;
      gcd_req.x     = per_ff;
      gcd_req.y     = ent_ff.per;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               a_in       = in_a;
               b_in       = req_tdata[9:5];
               present_in = req_tdata[10];
               per_in     = in_per;
               status_in  = tsa_pkg::ST_DONE;
               case (in_op)
                  tsa_pkg::OP_EDGE: begin
                     state_in = S_EDGE_RD;
                  end
                  tsa_pkg::OP_CLEAR: begin
                     entries_in    = '0;
                     sched_len_in  = LW'(sf_eff);
                     start_cnt_in  = '0;
                     len_before_in = LW'(sf_eff);
                     failed_in     = 1'b0;
                     next_off_in   = '0;
                     state_in      = S_FINISH;
                  end
                  tsa_pkg::OP_PLACE: begin
                     if (in_first) begin
                        start_cnt_in  = entries_ff;
                        len_before_in = sched_len_ff;
                        failed_in     = 1'b0;
                        next_off_in   = '0;
                        state_in      = S_HOP_RDA;
                     end else if (failed_ff) begin
                        status_in = tsa_pkg::ST_SKIPPED;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_HOP_RDA;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // Edge write: read row, write back patched
         S_EDGE_RD: begin
            state_in = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            if (a_ok && b_ok) begin
               adj_wr_en           = 1'b1;
               adj_valid_in[a_idx] = 1'b1;
            end
            state_in = S_FINISH;
         end

         // Hop: fetch both adjacency rows
         S_HOP_RDA: begin
            state_in = S_HOP_RDB;
         end
         S_HOP_RDB: begin
            adj_rd_addr = b_idx;
            row_a_in    = (a_ok && adj_valid_ff[a_idx]) ? adj_rd_data : '0;
            state_in    = S_HOP_CHK;
         end
         S_HOP_CHK: begin
            row_b_in = (b_ok && adj_valid_ff[b_idx]) ? adj_rd_data : '0;
            if (!(b_ok && row_a_ff[b_idx]) || (entries_ff >= EW'(MAX_ENTRIES))) begin
               status_in = (b_ok && row_a_ff[b_idx]) ? tsa_pkg::ST_FULL
                                                     : tsa_pkg::ST_NO_LINK;
               if (start_cnt_ff < entries_ff) begin
                  entries_in = start_cnt_ff;
               end
               sched_len_in = len_before_ff;
               failed_in    = 1'b1;
               state_in     = S_FINISH;
            end else begin
               limit_in = OW'(lim_prod - 1'b1);
               off_in   = next_off_ff;
               go_in    = 1'b1;
               state_in = S_DIV_OFF;
            end
         end

         // Split the start offset into tile and slot
         S_DIV_OFF: begin
            div_req.start = go_ff;
            if (div_rsp.done) begin
               sl_in    = div_rsp.rem[TW-1:0];
               go_in    = 1'b1;
               state_in = S_DIV_TILE;
            end
         end
         S_DIV_TILE: begin
            div_req.start = go_ff;
            div_req.num   = div_rsp.quot;
            div_req.den   = tsa_pkg::DIV_DEN_W'(sf_eff);
            if (div_rsp.done) begin
               ti_in    = div_rsp.rem[tsa_pkg::TIDX_W-1:0];
               state_in = S_SCAN;
            end
         end

         // Try one offset
         S_SCAN: begin
            if (off_ff >= limit_ff) begin
               status_in = tsa_pkg::ST_NO_SLOT;
               if (start_cnt_ff < entries_ff) begin
                  entries_in = start_cnt_ff;
               end
               sched_len_in = len_before_ff;
               failed_in    = 1'b1;
               state_in     = S_FINISH;
            end else if (ctrl_slot) begin
               off_in = off_step;
               sl_in  = sl_step;
               ti_in  = ti_step;
            end else begin
               i_in     = '0;
               state_in = S_ENT_RD;
            end
         end

         // Walk the stored entries
         S_ENT_RD: begin
            if (i_ff >= entries_ff) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_ENT_CHK;
            end
         end
         S_ENT_CHK: begin
            ent_in = tbl_rd_data;
            if (related) begin
               go_in    = 1'b1;
               state_in = S_GCD_M;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_ENT_RD;
            end
         end
         S_GCD_M: begin
            gcd_req.start = go_ff;
            if (gcd_rsp.done) begin
               m_in     = OW'(m_prod);
               go_in    = 1'b1;
               state_in = S_DIV_M;
            end
         end
         // Slot sets meet when the offsets agree modulo tile_slots*gcd
         S_DIV_M: begin
            div_req.start = go_ff;
            div_req.num   = tsa_pkg::DIV_NUM_W'(off_diff);
            div_req.den   = m_ff;
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  off_in   = off_step;
                  sl_in    = sl_step;
                  ti_in    = ti_step;
                  state_in = S_SCAN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_ENT_RD;
               end
            end
         end

         // Store the hop, then update the schedule length
         S_PLACE: begin
            tbl_wr_en   = 1'b1;
            entries_in  = entries_ff + 1'b1;
            next_off_in = off_step;
            go_in       = 1'b1;
            state_in    = S_LCM_DIV1;
         end
         S_LCM_DIV1: begin
            div_req.start = go_ff;
            div_req.num   = sched_len_ff;
            div_req.den   = tsa_pkg::DIV_DEN_W'(per_ff);
            if (div_rsp.done) begin
               go_in    = 1'b1;
               state_in = S_LCM_GCD;
            end
         end
         S_LCM_GCD: begin
            gcd_req.start = go_ff;
            gcd_req.y     = div_rsp.rem[PW-1:0];
            if (gcd_rsp.done) begin
               go_in    = 1'b1;
               state_in = S_LCM_DIV2;
            end
         end
         S_LCM_DIV2: begin
            div_req.start = go_ff;
            div_req.num   = tsa_pkg::DIV_NUM_W'(per_ff);
            div_req.den   = tsa_pkg::DIV_DEN_W'(gcd_rsp.g);
            if (div_rsp.done) begin
               prod_in  = tsa_pkg::PROD_W'(sched_len_ff) *
                          tsa_pkg::PROD_W'(div_rsp.quot[PW-1:0]);
               state_in = S_LCM_MUL;
            end
         end
         S_LCM_MUL: begin
            sched_len_in = (prod_ff > tsa_pkg::PROD_W'(tsa_pkg::LEN_SAT)) ?
                           tsa_pkg::LEN_SAT : prod_ff[LW-1:0];
            status_in    = tsa_pkg::ST_PLACED;
            state_in     = S_FINISH;
         end

         // Load the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_off_in    = (status_ff == tsa_pkg::ST_PLACED) ?
                               off_ff[tsa_pkg::SLOT_OFF_W-1:0] : '0;
               rsp_len_in    = sched_len_ff;
               rsp_cnt_in    = tsa_pkg::ENTRY_CNT_W'(entries_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         go_ff         <= 1'b0;
         entries_ff    <= '0;
         sched_len_ff  <= LW'(tsa_pkg::RST_SF);
         start_cnt_ff  <= '0;
         len_before_ff <= LW'(tsa_pkg::RST_SF);
         failed_ff     <= 1'b0;
         next_off_ff   <= '0;
         adj_valid_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         entries_ff    <= entries_in;
         sched_len_ff  <= sched_len_in;
         start_cnt_ff  <= start_cnt_in;
         len_before_ff <= len_before_in;
         failed_ff     <= failed_in;
         next_off_ff   <= next_off_in;
         adj_valid_ff  <= adj_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      present_ff    <= present_in;
      per_ff        <= per_in;
      status_ff     <= status_in;
      off_ff        <= off_in;
      sl_ff         <= sl_in;
      ti_ff         <= ti_in;
      limit_ff      <= limit_in;
      i_ff          <= i_in;
      ent_ff        <= ent_in;
      m_ff          <= m_in;
      prod_ff       <= prod_in;
      row_a_ff      <= row_a_in;
      row_b_ff      <= row_b_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // Topology rows
   tsa_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (a_idx),
      .wr_data (adj_wr_data),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   // Schedule table
   tsa_ram #(
      .WIDTH ($bits(tsa_pkg::ent_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (entries_ff[IW-1:0]),
      .wr_data (tbl_wr_data),
      .rd_addr (i_ff[IW-1:0]),
      .rd_data (tbl_rd_data)
   );

   tsa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tsa_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .req   (gcd_req),
      .rsp   (gcd_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_len_ff, rsp_off_ff};

endmodule
